@@ src/crsd_pkg.sv @@
`default_nettype none

package crsd_pkg;

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned ADDR_W     = 17;
  localparam int unsigned X_W        = 9;
  localparam int unsigned Y_W        = 8;
  localparam int unsigned PEND_W     = 6;

  // stream port widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 2'd2;
  localparam logic [COL_W-1:0]     FRAME_COLUMNS_RST = 10'd1;

  // column op codes and repeat coding
  localparam logic [BYTE_W-1:0] OP_SKIP     = 8'hFF;
  localparam logic [BYTE_W-1:0] OP_REPEAT   = 8'h80;
  localparam logic [BYTE_W-1:0] OP_LITERAL  = 8'h00;
  localparam logic [BYTE_W-1:0] REPEAT_BASE = 8'd224;
  localparam logic [BYTE_W-1:0] REPEAT_BIAS = 8'd223;

  localparam int unsigned DEF_ROW_PITCH = 320;

  typedef struct packed {
    logic [COL_W-1:0] frame_columns;
    logic [X_W-1:0]   dest_x;
    logic [Y_W-1:0]   dest_y;
  } crsd_cfg_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] pixel_value;
    logic [COL_W-1:0]  column_index;
    logic [ROW_W-1:0]  row_index;
    logic              end_of_frame;
    logic              last_result;
  } crsd_result_t;

endpackage

`default_nettype wire

@@ src/column_rle_sprite_decoder.sv @@
// channel  | direction | payload
// ---------+-----------+-----------------------------------------------------
// in_      | slave     | tdata: compressed frame byte
// out_     | master    | tdata: pixel address/value, column, row;
//          |           | tuser: write flag, frame end; tlast: last of byte
// cfg_     | write     | frame_columns, dest_x, dest_y
//
// one byte per cycle is taken when it gives at most one result item and out_tready does not stall
// a repeat run of n writes holds its value byte until all n writes are out
// a byte is held in the byte register and its result items in the result register
// rst_n is synchronous; it clears parse state and config to defaults
// out_tready low stalls the parser and, through it, the byte register
`default_nettype none

module column_rle_sprite_decoder import crsd_pkg::*; #(
  parameter int unsigned ROW_PITCH = DEF_ROW_PITCH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // stream_byte
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // pixel_address, pixel_value, column_index, row_index, zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // write_enable, end_of_frame
  output logic [OUT_USER_W-1:0]      out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  crsd_cfg_t         cfg_r;
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  crsd_result_t      out_res_r;
  logic              out_free;
  logic              step;
  logic              byte_done;
  logic              res_vld;
  crsd_result_t      res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_columns <= FRAME_COLUMNS_RST;
      cfg_r.dest_x        <= '0;
      cfg_r.dest_y        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_COLUMNS: cfg_r.frame_columns <= cfg_wdata[COL_W-1:0];
        CFG_DEST_X:        cfg_r.dest_x        <= cfg_wdata[X_W-1:0];
        CFG_DEST_Y:        cfg_r.dest_y        <= cfg_wdata[Y_W-1:0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // byte register
  assign in_tready = !in_vld_r || byte_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (byte_done) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[BYTE_W-1:0];
    end
  end

  crsd_parser #(
    .ROW_PITCH (ROW_PITCH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .byte_vld  (in_vld_r),
    .byte_in   (in_byte_r),
    .out_free  (out_free),
    .step      (step),
    .byte_done (byte_done),
    .res_vld   (res_vld),
    .res       (res)
  );

  // result register
  assign out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_res_r.row_index, out_res_r.column_index,
                       out_res_r.pixel_value, out_res_r.pixel_address};
  assign out_tuser  = {out_res_r.end_of_frame, out_res_r.write_enable};
  assign out_tlast  = out_res_r.last_result;

endmodule

`default_nettype wire

@@ src/crsd_parser.sv @@
`default_nettype none

module crsd_parser import crsd_pkg::*; #(
  parameter int unsigned ROW_PITCH = DEF_ROW_PITCH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire crsd_cfg_t         cfg,
  input  wire logic              byte_vld,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire logic              out_free,
  output logic                   step,
  output logic                   byte_done,
  output logic                   res_vld,
  output crsd_result_t           res
);

  typedef enum logic [2:0] {
    PH_OP,
    PH_PKT_COUNT,
    PH_OTHER_COUNT,
    PH_SEQ_LEN,
    PH_SEQ_SKIP,
    PH_DATA,
    PH_REP_VALUE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                rep_mode_r, rep_mode_nxt;
  logic [BYTE_W-1:0]   pkt_r, pkt_nxt;
  logic [BYTE_W-1:0]   seq_r, seq_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;

  logic                wr;
  logic                final_step;
  logic                end_col;
  logic                frame_end;
  logic [BYTE_W:0]     need;
  logic [BYTE_W-1:0]   seq_dec;
  logic [COL_W-1:0]    col_inc;
  logic [Y_W+2:0]      y_sum;
  logic [ADDR_W-1:0]   addr;

  // pixel address of the current write
  always_comb begin
    y_sum = (Y_W+3)'(cfg.dest_y) + (Y_W+3)'(row_r);
    addr  = ADDR_W'(y_sum) * ADDR_W'(ROW_PITCH) + ADDR_W'(cfg.dest_x) + ADDR_W'(col_r);
  end

  // byte decode and next state
  always_comb begin
    phase_nxt    = phase_r;
    rep_mode_nxt = rep_mode_r;
    pkt_nxt      = pkt_r;
    seq_nxt      = seq_r;
    pend_nxt     = pend_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    wr           = 1'b0;
    final_step   = 1'b1;
    end_col      = 1'b0;
    frame_end    = 1'b0;
    need         = {1'b0, byte_in} + 9'd2;
    seq_dec      = seq_r - 8'd1;
    col_inc      = col_r + 10'd1;

    case (phase_r)
      PH_OP: begin
        row_nxt = '0;
        if (byte_in == OP_SKIP) begin
          end_col = 1'b1;
        end else if (byte_in == OP_REPEAT || byte_in == OP_LITERAL) begin
          rep_mode_nxt = (byte_in == OP_REPEAT);
          phase_nxt    = PH_PKT_COUNT;
        end else begin
          phase_nxt = PH_OTHER_COUNT;
        end
      end
      PH_PKT_COUNT: begin
        pkt_nxt   = byte_in;
        phase_nxt = PH_SEQ_LEN;
      end
      PH_OTHER_COUNT: begin
        end_col = 1'b1;
      end
      PH_SEQ_LEN: begin
        seq_nxt   = byte_in;
        // count underflow clamps to zero so the column ends after this sequence
        pkt_nxt   = (need > {1'b0, pkt_r}) ? '0 : BYTE_W'({1'b0, pkt_r} - need);
        phase_nxt = PH_SEQ_SKIP;
      end
      PH_SEQ_SKIP: begin
        row_nxt = row_r + ROW_W'(byte_in);
        if (seq_r != '0) begin
          phase_nxt = PH_DATA;
        end else if (pkt_r == '0) begin
          end_col = 1'b1;
        end else begin
          phase_nxt = PH_SEQ_LEN;
        end
      end
      PH_DATA: begin
        seq_nxt = seq_dec;
        if (rep_mode_r && byte_in >= REPEAT_BASE) begin
          pend_nxt  = PEND_W'(byte_in - REPEAT_BIAS);
          phase_nxt = PH_REP_VALUE;
        end else begin
          wr      = 1'b1;
          row_nxt = row_r + 10'd1;
          if (seq_dec == '0) begin
            if (pkt_r == '0) begin
              end_col = 1'b1;
            end else begin
              phase_nxt = PH_SEQ_LEN;
            end
          end
        end
      end
      PH_REP_VALUE: begin
        // one write per cycle while the output is free; the byte is held until the run is out
        wr         = (pend_r != '0);
        final_step = (pend_r <= 6'd1);
        if (wr) begin
          row_nxt = row_r + 10'd1;
        end
        if (!final_step) begin
          pend_nxt = pend_r - 6'd1;
        end else begin
          pend_nxt = '0;
          seq_nxt  = (seq_r != '0) ? seq_dec : '0;
          if (seq_nxt != '0) begin
            phase_nxt = PH_DATA;
          end else if (pkt_r == '0) begin
            end_col = 1'b1;
          end else begin
            phase_nxt = PH_SEQ_LEN;
          end
        end
      end
      default: begin
        phase_nxt = PH_OP;
      end
    endcase

    // column end: next op byte, frame end when the count reaches frame_columns
    if (end_col) begin
      phase_nxt = PH_OP;
      pkt_nxt   = '0;
      seq_nxt   = '0;
      pend_nxt  = '0;
      if (col_inc == cfg.frame_columns) begin
        col_nxt   = '0;
        frame_end = 1'b1;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  // handshake toward the input and output registers
  assign step      = byte_vld && out_free;
  assign byte_done = step && final_step;
  assign res_vld   = wr || frame_end;

  // result item
  always_comb begin
    res.write_enable  = wr;
    res.pixel_address = wr ? addr : '0;
    res.pixel_value   = wr ? byte_in : '0;
    res.column_index  = col_r;
    res.row_index     = wr ? row_r : row_nxt;
    res.end_of_frame  = frame_end;
    res.last_result   = final_step;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OP;
      rep_mode_r <= 1'b0;
      pkt_r      <= '0;
      seq_r      <= '0;
      pend_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      rep_mode_r <= rep_mode_nxt;
      pkt_r      <= pkt_nxt;
      seq_r      <= seq_nxt;
      pend_r     <= pend_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/crsd_checker.sv @@
`default_nettype none

module crsd_checker import crsd_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser,
  input wire logic                  out_tlast
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result item changed");

  // frame end only on the last item of a byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("frame end not on last item");

  // an item without a write only marks a frame end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] && out_tlast)
    else $error("item without write outside frame end");

  // an item without a write carries zero address and value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[24:0] == 25'd0)
    else $error("item without write carries address or value");

  // no result item right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item after reset");

endmodule

bind column_rle_sprite_decoder crsd_checker u_crsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
  import crsd_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic [2:0] {
    PH_OP, PH_PKT_COUNT, PH_OTHER_COUNT, PH_SEQ_LEN, PH_SEQ_SKIP, PH_DATA, PH_REP_VALUE
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  column_rle_sprite_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // decoder state mirror
  parse_phase_t dec_phase = PH_OP;
  logic dec_repeat = 1'b0;
  logic [BYTE_W-1:0] pkt_left = '0;
  logic [BYTE_W-1:0] seq_left = '0;
  logic [PEND_W-1:0] rep_pending = '0;
  logic [COL_W-1:0] col_cnt = '0;
  logic [ROW_W-1:0] row_cnt = '0;
  logic [COL_W-1:0] cfg_columns = FRAME_COLUMNS_RST;
  logic [X_W-1:0] cfg_x = '0;
  logic [Y_W-1:0] cfg_y = '0;

  crsd_result_t pixel_writes_due[$];
  crsd_result_t byte_writes[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  bit send_fast = 1'b0;
  bit recv_fast = 1'b0;

  // one pixel write at the current row, then step down a row
  function automatic void emit_pixel(input logic [BYTE_W-1:0] v);
    crsd_result_t r;
    int a;
    a = (int'(cfg_y) + int'(row_cnt)) * int'(DEF_ROW_PITCH) + int'(cfg_x) + int'(col_cnt);
    r = '0;
    r.write_enable  = 1'b1;
    r.pixel_address = a[ADDR_W-1:0];
    r.pixel_value   = v;
    r.column_index  = col_cnt;
    r.row_index     = row_cnt;
    byte_writes.push_back(r);
    row_cnt = row_cnt + 1'b1;
  endfunction

  function automatic bit finish_column();
    logic [COL_W-1:0] nxt;
    nxt = col_cnt + 1'b1;
    dec_phase   = PH_OP;
    pkt_left    = '0;
    seq_left    = '0;
    rep_pending = '0;
    if (nxt == cfg_columns) begin
      col_cnt = '0;
      return 1'b1;
    end
    col_cnt = nxt;
    return 1'b0;
  endfunction

  function automatic bit finish_sequence();
    if (pkt_left == 0) return finish_column();
    dec_phase = PH_SEQ_LEN;
    return 1'b0;
  endfunction

  // work out the pixel writes one compressed byte causes
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    logic [COL_W-1:0] fin_col;
    bit eof;
    int need;
    int last;
    crsd_result_t r;
    fin_col = col_cnt;
    eof = 1'b0;
    byte_writes.delete();
    case (dec_phase)
      PH_OP: begin
        row_cnt = '0;
        if (b == OP_SKIP) begin
          eof = finish_column();
        end else if (b == OP_REPEAT || b == OP_LITERAL) begin
          dec_repeat = (b == OP_REPEAT);
          dec_phase = PH_PKT_COUNT;
        end else begin
          dec_phase = PH_OTHER_COUNT;
        end
      end
      PH_PKT_COUNT: begin
        pkt_left = b;
        dec_phase = PH_SEQ_LEN;
      end
      PH_OTHER_COUNT: eof = finish_column();
      PH_SEQ_LEN: begin
        seq_left = b;
        need = int'(b) + 2;
        // count underflow clamps to zero
        pkt_left = (need > int'(pkt_left)) ? 8'd0 : 8'(int'(pkt_left) - need);
        dec_phase = PH_SEQ_SKIP;
      end
      PH_SEQ_SKIP: begin
        row_cnt = row_cnt + b;
        if (seq_left == 0) eof = finish_sequence();
        else dec_phase = PH_DATA;
      end
      PH_DATA: begin
        seq_left = seq_left - 1'b1;
        if (dec_repeat && b >= REPEAT_BASE) begin
          rep_pending = PEND_W'(b - REPEAT_BIAS);
          dec_phase = PH_REP_VALUE;
        end else begin
          emit_pixel(b);
          if (seq_left == 0) eof = finish_sequence();
        end
      end
      PH_REP_VALUE: begin
        // a repeat on the last counted byte still takes its value byte
        if (seq_left > 0) seq_left = seq_left - 1'b1;
        while (rep_pending > 0 && byte_writes.size() < 32) begin
          emit_pixel(b);
          rep_pending = rep_pending - 1'b1;
        end
        rep_pending = '0;
        if (seq_left == 0) eof = finish_sequence();
        else dec_phase = PH_DATA;
      end
      default: dec_phase = PH_OP;
    endcase
    // frame end with no write still reports once
    if (eof && byte_writes.size() == 0) begin
      r = '0;
      r.column_index = fin_col;
      r.row_index = row_cnt;
      byte_writes.push_back(r);
    end
    if (byte_writes.size() > 0) begin
      last = byte_writes.size() - 1;
      r = byte_writes[last];
      r.last_result = 1'b1;
      r.end_of_frame = eof;
      byte_writes[last] = r;
    end
    foreach (byte_writes[i]) pixel_writes_due.push_back(byte_writes[i]);
  endfunction

  // send one compressed byte after a random gap
  task automatic feed_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic feed_list(input logic [BYTE_W-1:0] bytes[$]);
    foreach (bytes[i]) feed_byte(bytes[i]);
  endtask

  // hold the sender until every due write has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pixel_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_decoder(input logic [COL_W-1:0] fc, input logic [X_W-1:0] x,
                                 input logic [Y_W-1:0] y);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_COLUMNS;
    cfg_wdata <= fc;
    @(posedge clk);
    cfg_columns = fc;
    cfg_index <= CFG_DEST_X;
    cfg_wdata <= CFG_DATA_W'(x);
    @(posedge clk);
    cfg_x = x;
    cfg_index <= CFG_DEST_Y;
    cfg_wdata <= CFG_DATA_W'(y);
    @(posedge clk);
    cfg_y = y;
    cfg_we <= 1'b0;
  endtask

  // one packet column with random content, sometimes with a short count
  task automatic feed_packet(input bit rep);
    int nseq;
    int lens[4];
    int total;
    int rem;
    bit short_count;
    nseq = $urandom_range(1, 4);
    short_count = ($urandom_range(0, 9) == 0);
    if (short_count) nseq = 1;
    total = 0;
    for (int i = 0; i < nseq; i++) begin
      lens[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
      total += lens[i] + 2;
    end
    feed_byte(rep ? OP_REPEAT : OP_LITERAL);
    feed_byte(short_count ? 8'($urandom_range(0, lens[0] + 1)) : 8'(total));
    for (int i = 0; i < nseq; i++) begin
      feed_byte(8'(lens[i]));
      feed_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(200, 255))
                                            : 8'($urandom_range(0, 15)));
      rem = lens[i];
      while (rem > 0) begin
        if (rep && $urandom_range(0, 3) == 0) begin
          feed_byte(8'($urandom_range(REPEAT_BASE, 255)));
          feed_byte(8'($urandom_range(0, 255)));
          rem -= (rem >= 2) ? 2 : 1;
        end else begin
          feed_byte(rep ? 8'($urandom_range(0, REPEAT_BASE - 1)) : 8'($urandom_range(0, 255)));
          rem--;
        end
      end
    end
  endtask

  task automatic feed_column();
    int kind;
    logic [BYTE_W-1:0] op;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      feed_byte(OP_SKIP);
    end else if (kind == 1) begin
      do op = 8'($urandom_range(0, 255));
      while (op == OP_SKIP || op == OP_REPEAT || op == OP_LITERAL);
      feed_byte(op);
      feed_byte(8'($urandom_range(0, 255)));
    end else begin
      feed_packet(kind >= 5);
    end
  endtask

  // reset config: one-column frames at the buffer origin
  task automatic test_reset_defaults();
    feed_list('{OP_SKIP});
    feed_list('{OP_LITERAL, 8'd5, 8'd3, 8'd2, 8'h0A, 8'hFF, REPEAT_BASE});
  endtask

  // other op, empty sequence, long repeat, repeat on last byte, count underflow
  task automatic test_column_ops();
    program_decoder(10'd4, 9'd319, 8'd199);
    feed_list('{8'h37, 8'h99});
    feed_list('{OP_LITERAL, 8'd2, 8'd0, 8'hFF});
    feed_list('{OP_REPEAT, 8'd6, 8'd4, 8'hFF, 8'hFF, 8'h5A, 8'h7F, REPEAT_BASE, 8'hA5});
    feed_list('{OP_LITERAL, 8'd1, 8'd2, 8'd3, 8'h11, 8'h22});
  endtask

  // frame length changed in the middle of a frame
  task automatic test_frame_length();
    program_decoder(10'd1023, 9'd0, 8'd0);
    repeat (3) feed_byte(OP_SKIP);
    program_decoder(10'd4, 9'd17, 8'd3);
    feed_byte(OP_SKIP);
  endtask

  // random frames, mostly well-formed, some noise bytes and new settings
  task automatic test_random_frames();
    int stop_at;
    stop_at = bytes_sent + 115;
    program_decoder(10'd3, 9'($urandom_range(0, 319)), 8'($urandom_range(0, 199)));
    while (bytes_sent < stop_at) begin
      send_fast = ($urandom_range(0, 4) == 0);
      recv_fast = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 14) == 0) feed_byte(8'($urandom_range(0, 255)));
      else feed_column();
      if (dec_phase == PH_OP && col_cnt == 0 && $urandom_range(0, 3) == 0) begin
        program_decoder(10'($urandom_range(1, 6)),
                        ($urandom_range(0, 3) == 0) ? 9'd319 : 9'($urandom_range(0, 319)),
                        ($urandom_range(0, 3) == 0) ? 8'd199 : 8'($urandom_range(0, 199)));
      end
    end
    send_fast = 1'b0;
    recv_fast = 1'b0;
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_pixel_write();
    crsd_result_t want;
    if (pixel_writes_due.size() == 0) begin
      $error("result item with no write due: tdata %h tuser %b", out_tdata, out_tuser);
      mismatches++;
      return;
    end
    want = pixel_writes_due.pop_front();
    compare_field("write_enable", want.write_enable, out_tuser[0]);
    compare_field("pixel_address", want.pixel_address, out_tdata[16:0]);
    compare_field("pixel_value", want.pixel_value, out_tdata[24:17]);
    compare_field("column_index", want.column_index, out_tdata[34:25]);
    compare_field("row_index", want.row_index, out_tdata[44:35]);
    compare_field("end_of_frame", want.end_of_frame, out_tuser[1]);
    compare_field("last_result", want.last_result, out_tlast);
  endfunction

  // result side: random stalls, check each accepted item
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = recv_fast ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_pixel_write();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_column_ops();
    test_frame_length();
    test_random_frames();
    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ column_rle_sprite_decoder.f @@
src/crsd_pkg.sv
src/crsd_parser.sv
src/column_rle_sprite_decoder.sv
src/crsd_checker.sv
test/tb.sv
